// ===== hw/rtl/rv32i_dec_pkg.sv =====
// rv32i decoder types, opcode constants and operation lookup tables
package rv32i_dec_pkg;

    localparam int unsigned INSTR_W = 32;

    // major opcodes, bits 6..0
    localparam logic [6:0] OPC_R      = 7'h33;
    localparam logic [6:0] OPC_IALU   = 7'h13;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;

    // funct7 codes
    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    // funct3 codes that select special handling
    localparam logic [2:0] F3_ADD_SUB = 3'd0;
    localparam logic [2:0] F3_SLL     = 3'd1;
    localparam logic [2:0] F3_SRL_SRA = 3'd5;
    localparam logic [2:0] F3_JALR    = 3'd0;

    typedef enum logic [2:0] {
        FMT_UNKNOWN = 3'd0,
        FMT_R       = 3'd1,
        FMT_I       = 3'd2,
        FMT_S       = 3'd3,
        FMT_SB      = 3'd4,
        FMT_U       = 3'd5,
        FMT_UJ      = 3'd6
    } format_t;

    typedef enum logic [5:0] {
        OP_UNKNOWN = 6'd0,
        OP_ADD     = 6'd1,
        OP_SUB     = 6'd2,
        OP_AND     = 6'd3,
        OP_OR      = 6'd4,
        OP_XOR     = 6'd5,
        OP_SLL     = 6'd6,
        OP_SRL     = 6'd7,
        OP_SRA     = 6'd8,
        OP_SLT     = 6'd9,
        OP_SLTU    = 6'd10,
        OP_LB      = 6'd11,
        OP_LH      = 6'd12,
        OP_LW      = 6'd13,
        OP_JALR    = 6'd14,
        OP_ADDI    = 6'd15,
        OP_ANDI    = 6'd16,
        OP_ORI     = 6'd17,
        OP_XORI    = 6'd18,
        OP_SLTI    = 6'd19,
        OP_SLTIU   = 6'd20,
        OP_SLLI    = 6'd21,
        OP_SRLI    = 6'd22,
        OP_SRAI    = 6'd23,
        OP_SB      = 6'd24,
        OP_SH      = 6'd25,
        OP_SW      = 6'd26,
        OP_BEQ     = 6'd27,
        OP_BNE     = 6'd28,
        OP_BLT     = 6'd29,
        OP_BGE     = 6'd30,
        OP_LUI     = 6'd31,
        OP_AUIPC   = 6'd32,
        OP_JAL     = 6'd33
    } op_t;

    // operation by funct3
    localparam op_t R_OPS_BASE [8] = '{
        OP_ADD, OP_SLL, OP_SLT, OP_SLTU, OP_XOR, OP_SRL, OP_OR, OP_AND
    };
    localparam op_t I_OPS [8] = '{
        OP_ADDI, OP_SLLI, OP_SLTI, OP_SLTIU, OP_XORI, OP_SRLI, OP_ORI, OP_ANDI
    };
    localparam op_t LOAD_OPS [8] = '{
        OP_LB, OP_LH, OP_LW, OP_UNKNOWN, OP_UNKNOWN, OP_UNKNOWN, OP_UNKNOWN, OP_UNKNOWN
    };
    localparam op_t STORE_OPS [8] = '{
        OP_SB, OP_SH, OP_SW, OP_UNKNOWN, OP_UNKNOWN, OP_UNKNOWN, OP_UNKNOWN, OP_UNKNOWN
    };
    localparam op_t BR_OPS [8] = '{
        OP_BEQ, OP_BNE, OP_UNKNOWN, OP_UNKNOWN, OP_BLT, OP_BGE, OP_UNKNOWN, OP_UNKNOWN
    };

endpackage

// ===== hw/rtl/rv32i_instruction_decoder_top.sv =====
// rv32i instruction decoder: input register, decode logic, result register
//
// usage
//   s_ channel: one 32-bit instruction word per transaction (s_valid/s_ready)
//   m_ channel: one decoded result per transaction (m_valid/m_ready): format,
//   operation code, rd/rs1/rs2, funct3, funct7 and the sign-extended immediate
//   path: a word accepted on s_ is held in the input stage, decoded, and
//   registered in the result stage before its result is offered on m_
//   throughput: one transaction per cycle while m_ready stays high; the two register
//   stages (input word, decoded result) each advance when the next one is
//   empty or being drained, so back-to-back words flow with no bubbles
//   stall: when m_ready is low the result holds, the input stage fills behind
//   it, and s_ready drops only once both stages hold a word; s_ready follows
//   m_ready combinationally in that case, so nothing is lost or repeated
//   reset: synchronous active-low aresetn empties both stages; no other state
//   unknown opcodes give format 0, operation 0 and a zero immediate; the
//   register and funct fields always carry the raw bit slices
module rv32i_instruction_decoder_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [rv32i_dec_pkg::INSTR_W-1:0]    s_instr_word,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [2:0]                           m_format,
    output logic [5:0]                           m_operation,
    output logic [4:0]                           m_dest_reg,
    output logic [4:0]                           m_src1_reg,
    output logic [4:0]                           m_src2_reg,
    output logic [2:0]                           m_func3_field,
    output logic [6:0]                           m_func7_field,
    output logic signed [rv32i_dec_pkg::INSTR_W-1:0] m_immediate
);
    import rv32i_dec_pkg::*;

    // input stage
    logic               in_valid_reg;
    logic [INSTR_W-1:0] instr_reg;

    // result stage
    logic               out_valid_reg;
    format_t            format_reg;
    op_t                op_reg;
    logic [INSTR_W-1:0] imm_reg;
    logic [4:0]         rd_reg;
    logic [4:0]         rs1_reg;
    logic [4:0]         rs2_reg;
    logic [2:0]         f3_reg;
    logic [6:0]         f7_reg;

    // decode of the input stage
    format_t            format_next;
    op_t                op_next;
    logic [INSTR_W-1:0] imm_next;

    logic [6:0]         opc;
    logic [2:0]         f3;
    logic [6:0]         f7;

    logic               out_load;
    logic               in_load;

    // result stage takes a new word when it is empty or being drained
    assign out_load = !out_valid_reg || m_ready;
    // input stage is free when empty or moving into the result stage
    assign s_ready  = !in_valid_reg || out_load;
    assign in_load  = s_valid && s_ready;

    assign opc = instr_reg[6:0];
    assign f3  = instr_reg[14:12];
    assign f7  = instr_reg[31:25];

    always_comb begin
        format_next = FMT_UNKNOWN;
        op_next     = OP_UNKNOWN;
        imm_next    = '0;
        unique case (opc) inside
            OPC_R: begin
                format_next = FMT_R;
                if (f7 == F7_BASE) begin
                    op_next = R_OPS_BASE[f3];
                end else if (f7 == F7_ALT && f3 == F3_ADD_SUB) begin
                    op_next = OP_SUB;
                end else if (f7 == F7_ALT && f3 == F3_SRL_SRA) begin
                    op_next = OP_SRA;
                end
            end
            OPC_IALU, OPC_LOAD, OPC_JALR: begin
                format_next = FMT_I;
                imm_next    = {{20{instr_reg[31]}}, instr_reg[31:20]};
                if (opc == OPC_LOAD) begin
                    op_next = LOAD_OPS[f3];
                end else if (opc == OPC_JALR) begin
                    if (f3 == F3_JALR) begin
                        op_next = OP_JALR;
                    end
                end else if (f3 == F3_SLL) begin
                    if (f7 == F7_BASE) begin
                        op_next = OP_SLLI;
                    end
                end else if (f3 == F3_SRL_SRA) begin
                    if (f7 == F7_BASE) begin
                        op_next = OP_SRLI;
                    end else if (f7 == F7_ALT) begin
                        op_next = OP_SRAI;
                    end
                end else begin
                    op_next = I_OPS[f3];
                end
            end
            OPC_STORE: begin
                format_next = FMT_S;
                imm_next    = {{20{instr_reg[31]}}, instr_reg[31:25], instr_reg[11:7]};
                op_next     = STORE_OPS[f3];
            end
            OPC_BRANCH: begin
                format_next = FMT_SB;
                imm_next    = {{19{instr_reg[31]}}, instr_reg[31], instr_reg[7],
                               instr_reg[30:25], instr_reg[11:8], 1'b0};
                op_next     = BR_OPS[f3];
            end
            OPC_LUI, OPC_AUIPC: begin
                format_next = FMT_U;
                imm_next    = {instr_reg[31:12], 12'b0};
                op_next     = (opc == OPC_LUI) ? OP_LUI : OP_AUIPC;
            end
            OPC_JAL: begin
                format_next = FMT_UJ;
                imm_next    = {{11{instr_reg[31]}}, instr_reg[31], instr_reg[19:12],
                               instr_reg[20], instr_reg[30:21], 1'b0};
                op_next     = OP_JAL;
            end
            default: begin
                format_next = FMT_UNKNOWN;
                op_next     = OP_UNKNOWN;
                imm_next    = '0;
            end
        endcase
    end

    // valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_load) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        if (in_load) begin
            instr_reg <= s_instr_word;
        end
        if (out_load && in_valid_reg) begin
            format_reg <= format_next;
            op_reg     <= op_next;
            imm_reg    <= imm_next;
            rd_reg     <= instr_reg[11:7];
            rs1_reg    <= instr_reg[19:15];
            rs2_reg    <= instr_reg[24:20];
            f3_reg     <= f3;
            f7_reg     <= f7;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_format      = format_reg;
    assign m_operation   = op_reg;
    assign m_dest_reg    = rd_reg;
    assign m_src1_reg    = rs1_reg;
    assign m_src2_reg    = rs2_reg;
    assign m_func3_field = f3_reg;
    assign m_func7_field = f7_reg;
    assign m_immediate   = imm_reg;

    // input side only backs up when both stages are full and the receiver stalls
    a_ready_low_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("s_ready low without a full pipeline");

    // an unknown opcode yields no operation and no immediate
    a_unknown_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_format == FMT_UNKNOWN) |-> (m_operation == OP_UNKNOWN && m_immediate == 0))
        else $error("unknown opcode with operation or immediate");

    // r-type has no immediate, u-type immediate has clear low bits
    a_imm_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_format == FMT_R || m_format == FMT_U)) |-> (m_immediate[11:0] == 12'd0))
        else $error("immediate low bits set for r or u format");

    // a decoded word in the input stage is valid in the result stage in the cycle after the result stage loads
    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_load) |=> out_valid_reg)
        else $error("word lost between input and result stage");

endmodule
